// ----- src/linear_probe_hash_table_assert.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the linear-probe hash table
// Clocked property wrappers for the RTL file that carries checks (lpht_probe_seq).
// ----------------------------------------------------------------------------
`ifndef LINEAR_PROBE_HASH_TABLE_ASSERT_SVH
`define LINEAR_PROBE_HASH_TABLE_ASSERT_SVH

// Check that holds at every edge once reset is released.
`define LPHT_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// Check that also holds while reset is asserted.
`define LPHT_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) prop) else $error(msg);

`endif

// ----- src/lpht_pkg.sv -----
// ----------------------------------------------------------------------------
// lpht_pkg
// Sizes, status codes and shared types of the linear-probe hash table.
// ----------------------------------------------------------------------------
package lpht_pkg;

    // Table geometry. SLOTS must stay a power of two: the home slot is the
    // low bits of the key.
    localparam int SLOTS    = 1024;
    localparam int KEY_BITS = 16;
    localparam int SLOT_W   = $clog2(SLOTS);
    localparam int CNT_W    = $clog2(SLOTS + 1);

    // Port field widths
    localparam int KEY_IN_W = 16;
    localparam int VALUE_W  = 32;
    localparam int STAT_W   = 3;
    localparam int SUM_W    = 32;
    localparam int CNT_OUT_W = 11;

    // Request kinds
    localparam logic REQ_INSERT = 1'b0;
    localparam logic REQ_SEARCH = 1'b1;

    // Result status codes
    localparam logic [STAT_W-1:0] ST_INSERTED  = 3'd0;
    localparam logic [STAT_W-1:0] ST_DUPLICATE = 3'd1;
    localparam logic [STAT_W-1:0] ST_FULL      = 3'd2;
    localparam logic [STAT_W-1:0] ST_FOUND     = 3'd3;
    localparam logic [STAT_W-1:0] ST_NOT_FOUND = 3'd4;

    // One slot of the table as stored in RAM
    typedef struct packed {
        logic                valid;
        logic [KEY_BITS-1:0] key;
        logic [VALUE_W-1:0]  value;
    } slot_entry_t;

    localparam int ENTRY_W = $bits(slot_entry_t);

    // RAM access requested by the sequencer
    typedef struct packed {
        logic              we;
        logic [SLOT_W-1:0] waddr;
        slot_entry_t       wdata;
        logic [SLOT_W-1:0] raddr;
    } ram_ctrl_t;

    // Finished request result
    typedef struct packed {
        logic [STAT_W-1:0]    status;
        logic [CNT_OUT_W-1:0] compares;
        logic [VALUE_W-1:0]   found_value;
        logic [CNT_OUT_W-1:0] entries;
        logic [SUM_W-1:0]     total;
    } result_t;

endpackage

// ----- src/lpht_slot_ram.sv -----
// ----------------------------------------------------------------------------
// lpht_slot_ram
// Simple dual-port RAM: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module lpht_slot_ram #(
    parameter int DEPTH  = 1024,
    parameter int WIDTH  = 49,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              aclk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // Read port, registered read data
    always_ff @(posedge aclk) begin
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- src/lpht_probe_seq.sv -----
// ----------------------------------------------------------------------------
// lpht_probe_seq
// Probe sequencer: clears the table after reset, then walks slots one per
// cycle with a single key comparator and slot incrementer per request.
// ----------------------------------------------------------------------------
module lpht_probe_seq
    import lpht_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    // request side
    input  logic                in_valid,
    output logic                in_ready,
    input  logic                in_type,
    input  logic [KEY_IN_W-1:0] in_key,
    input  logic [VALUE_W-1:0]  in_value,
    // slot RAM
    output ram_ctrl_t           ram_ctrl,
    input  slot_entry_t         rd_entry,
    // result side
    input  logic                out_free,
    output logic                res_valid,
    output result_t             res
);

    `include "linear_probe_hash_table_assert.svh"

    localparam logic [1:0] ST_CLEAR = 2'd0;
    localparam logic [1:0] ST_IDLE  = 2'd1;
    localparam logic [1:0] ST_PROBE = 2'd2;

    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(SLOTS - 1);

    logic [1:0]          state_reg, state_next;
    logic [SLOT_W-1:0]   clr_addr_reg, clr_addr_next;
    logic [SLOT_W-1:0]   pos_reg, pos_next;
    logic [SLOT_W-1:0]   home_reg, home_next;
    logic [KEY_BITS-1:0] key_reg, key_next;
    logic [VALUE_W-1:0]  value_reg, value_next;
    logic                search_reg, search_next;
    logic [CNT_W-1:0]    cmp_reg, cmp_next;
    logic [CNT_W-1:0]    entry_count_reg, entry_count_next;
    logic [SUM_W-1:0]    sum_reg, sum_next;

    logic                accept;
    logic [KEY_BITS-1:0] key_in;
    logic                hit;
    logic                lap;
    logic                done;
    logic                finish;
    logic                do_write;
    logic [SLOT_W-1:0]   pos_inc;
    logic [CNT_W-1:0]    cmp_now;
    logic [SUM_W:0]      sum_add;
    logic [SUM_W-1:0]    sum_upd;
    logic [CNT_W-1:0]    entries_upd;
    logic [STAT_W-1:0]   status_now;

    assign in_ready = (state_reg == ST_IDLE);
    assign accept   = in_valid && in_ready;
    assign key_in   = KEY_BITS'(in_key);

    // Shared probe datapath: key compare and slot step
    assign hit     = rd_entry.valid && (rd_entry.key == key_reg);
    assign pos_inc = (pos_reg == LAST_SLOT) ? '0 : pos_reg + SLOT_W'(1);
    assign lap     = rd_entry.valid && !hit && (pos_inc == home_reg);
    assign done    = !rd_entry.valid || hit || lap;
    assign cmp_now = cmp_reg + CNT_W'(rd_entry.valid);

    // Request ends this cycle only if the output register can take it
    assign finish   = (state_reg == ST_PROBE) && done && out_free;
    assign do_write = finish && !rd_entry.valid && (search_reg == REQ_INSERT);

    // Saturating running total of search comparisons
    assign sum_add = {1'b0, sum_reg} + (SUM_W + 1)'(cmp_now);
    assign sum_upd = sum_add[SUM_W] ? '1 : sum_add[SUM_W-1:0];

    assign entries_upd = entry_count_reg + CNT_W'(do_write);

    // Status of the ending probe
    always_comb begin
        if (!rd_entry.valid) begin
            status_now = (search_reg == REQ_SEARCH) ? ST_NOT_FOUND : ST_INSERTED;
        end else if (hit) begin
            status_now = (search_reg == REQ_SEARCH) ? ST_FOUND : ST_DUPLICATE;
        end else begin
            status_now = (search_reg == REQ_SEARCH) ? ST_NOT_FOUND : ST_FULL;
        end
    end

    // Sequencer
    always_comb begin
        state_next       = state_reg;
        clr_addr_next    = clr_addr_reg;
        pos_next         = pos_reg;
        home_next        = home_reg;
        key_next         = key_reg;
        value_next       = value_reg;
        search_next      = search_reg;
        cmp_next         = cmp_reg;
        entry_count_next = entry_count_reg;
        sum_next         = sum_reg;

        case (state_reg)
            ST_CLEAR: begin
                clr_addr_next = clr_addr_reg + SLOT_W'(1);
                if (clr_addr_reg == LAST_SLOT) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (accept) begin
                    key_next    = key_in;
                    value_next  = in_value;
                    search_next = in_type;
                    home_next   = SLOT_W'(key_in % SLOTS);
                    pos_next    = SLOT_W'(key_in % SLOTS);
                    cmp_next    = '0;
                    state_next  = ST_PROBE;
                end
            end
            ST_PROBE: begin
                if (!done) begin
                    pos_next = pos_inc;
                    cmp_next = cmp_now;
                end else if (finish) begin
                    entry_count_next = entries_upd;
                    if (search_reg == REQ_SEARCH) begin
                        sum_next = sum_upd;
                    end
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_CLEAR;
            clr_addr_reg    <= '0;
            entry_count_reg <= '0;
            sum_reg         <= '0;
        end else begin
            state_reg       <= state_next;
            clr_addr_reg    <= clr_addr_next;
            entry_count_reg <= entry_count_next;
            sum_reg         <= sum_next;
        end
    end

    // Per-request payload, no reset needed
    always_ff @(posedge aclk) begin
        pos_reg    <= pos_next;
        home_reg   <= home_next;
        key_reg    <= key_next;
        value_reg  <= value_next;
        search_reg <= search_next;
        cmp_reg    <= cmp_next;
    end

    // RAM access: clear pass, insert write, read of the next probed slot
    always_comb begin
        ram_ctrl             = '0;
        ram_ctrl.raddr       = pos_next;
        if (state_reg == ST_CLEAR) begin
            ram_ctrl.we    = 1'b1;
            ram_ctrl.waddr = clr_addr_reg;
        end else if (do_write) begin
            ram_ctrl.we          = 1'b1;
            ram_ctrl.waddr       = pos_reg;
            ram_ctrl.wdata.valid = 1'b1;
            ram_ctrl.wdata.key   = key_reg;
            ram_ctrl.wdata.value = value_reg;
        end
    end

    // Result
    assign res_valid       = finish;
    assign res.status      = status_now;
    assign res.compares    = CNT_OUT_W'(cmp_now);
    assign res.found_value = (hit && search_reg == REQ_SEARCH) ? rd_entry.value : '0;
    assign res.entries     = CNT_OUT_W'(entries_upd);
    assign res.total       = (search_reg == REQ_SEARCH) ? sum_upd : sum_reg;

    // Checks
    `LPHT_ASSERT(a_count_bound, entry_count_reg <= CNT_W'(SLOTS), "entry count above table size")
    `LPHT_ASSERT(a_cmp_bound, (state_reg == ST_PROBE) |-> (cmp_reg < CNT_W'(SLOTS)), "probe count past a full lap")
    `LPHT_ASSERT(a_insert_count, (res_valid && res.status == ST_INSERTED) |=> (entry_count_reg == $past(entry_count_reg) + CNT_W'(1)), "insert did not bump count")
    `LPHT_ASSERT_ALWAYS(a_no_accept_in_reset, !aresetn |=> !in_ready, "request taken during clear pass")

endmodule

// ----- src/linear_probe_hash_table.sv -----
// ----------------------------------------------------------------------------
// linear_probe_hash_table
// Open-addressing hash table with linear probing, insert and search requests.
// ----------------------------------------------------------------------------
// After reset the block clears every slot of the slot RAM, with s_tready
// low. A request then visits from 1 up to 1024 slots (1024 on a full lap):
// one slot RAM read per cycle through a single compare unit while the
// walk goes on, after a state that takes the request. The result sits in
// an output register, so the next request is taken while a result waits;
// a request that finishes while the previous result is still unread holds
// until it is taken.
// ----------------------------------------------------------------------------
module linear_probe_hash_table
    import lpht_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    // request: tuser = req_type
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // [15:0] key_in, [47:16] value_in
    input  logic        s_tuser,   // [0] req_type
    // result
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [95:0] m_tdata    // [2:0] status, [13:3] probe_compares,
                                   // [45:14] found_value, [56:46] entries_now,
                                   // [88:57] compare_total, [95:89] zero
);

    ram_ctrl_t   ram_ctrl;
    slot_entry_t rd_entry;
    logic [ENTRY_W-1:0] rd_raw;
    logic        out_free;
    logic        res_valid;
    result_t     res;

    logic        m_tvalid_reg, m_tvalid_next;
    result_t     m_res_reg;

    assign out_free = !m_tvalid_reg || m_tready;

    lpht_slot_ram #(
        .DEPTH  (SLOTS),
        .WIDTH  (ENTRY_W),
        .ADDR_W (SLOT_W)
    ) u_ram (
        .aclk  (aclk),
        .we    (ram_ctrl.we),
        .waddr (ram_ctrl.waddr),
        .wdata (ram_ctrl.wdata),
        .raddr (ram_ctrl.raddr),
        .rdata (rd_raw)
    );

    assign rd_entry = slot_entry_t'(rd_raw);

    lpht_probe_seq u_seq (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_type   (s_tuser),
        .in_key    (s_tdata[15:0]),
        .in_value  (s_tdata[47:16]),
        .ram_ctrl  (ram_ctrl),
        .rd_entry  (rd_entry),
        .out_free  (out_free),
        .res_valid (res_valid),
        .res       (res)
    );

    // Output register
    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        if (res_valid) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else begin
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_valid) begin
            m_res_reg <= res;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {7'd0, m_res_reg.total, m_res_reg.entries, m_res_reg.found_value,
                       m_res_reg.compares, m_res_reg.status};

endmodule

// ----- bench/linear_probe_hash_table_tb.sv -----
// ----------------------------------------------------------------------------
// linear_probe_hash_table_tb
// Self-checking bench for the linear-probe hash table. Insert and search
// transactions go in on the request stream. A scoreboard keeps its own copy
// of the table, works out each expected result in order and checks every
// result transaction field by field. The run covers collisions, wraparound,
// duplicates, clustered random traffic, a full table and full-lap probes.
// ----------------------------------------------------------------------------
module linear_probe_hash_table_tb;
    import lpht_pkg::*;

    localparam int QUIET_LIMIT  = 20000;  // cycles without any transaction
    localparam int MAX_SHOWN    = 10;
    localparam int RANDOM_ITEMS = 1400;
    localparam int POOL_SIZE    = 400;
    localparam int CLUSTER_KEYS = 150;

    // ------------------------------------------------------------------------
    // Scoreboard: shadow table plus the queue of results still outstanding
    // ------------------------------------------------------------------------
    class hash_table_scoreboard;
        bit                  slot_used [SLOTS];
        bit [KEY_BITS-1:0]   slot_key  [SLOTS];
        bit [VALUE_W-1:0]    slot_val  [SLOTS];
        int unsigned         entry_count;
        bit [SUM_W-1:0]      search_sum;
        result_t             pending_results [$];
        int unsigned         errors;
        int unsigned         checked;
        int unsigned         requests;
        int unsigned         status_tally [8];

        function new();
            entry_count = 0;
            search_sum  = '0;
            errors      = 0;
            checked     = 0;
            requests    = 0;
            foreach (slot_used[s]) slot_used[s] = 1'b0;
            foreach (status_tally[s]) status_tally[s] = 0;
        endfunction

        // Walk the probe sequence for one accepted request
        function void note_request(logic kind, logic [KEY_IN_W-1:0] key_raw,
                                   logic [VALUE_W-1:0] value);
            bit [KEY_BITS-1:0] key;
            int unsigned       home;
            int unsigned       pos;
            int unsigned       compares;
            bit                done;
            longint unsigned   sum_wide;
            result_t           r;
            key      = key_raw[KEY_BITS-1:0];
            home     = key % SLOTS;
            pos      = home;
            compares = 0;
            done     = 1'b0;
            r        = '0;
            r.status = (kind == REQ_SEARCH) ? ST_NOT_FOUND : ST_FULL;
            while (!done) begin
                if (!slot_used[pos]) begin
                    // empty slot: insert lands here, search misses
                    if (kind == REQ_INSERT) begin
                        slot_used[pos] = 1'b1;
                        slot_key[pos]  = key;
                        slot_val[pos]  = value;
                        entry_count++;
                        r.status = ST_INSERTED;
                    end
                    done = 1'b1;
                end else begin
                    compares++;
                    if (slot_key[pos] == key) begin
                        if (kind == REQ_SEARCH) begin
                            r.status      = ST_FOUND;
                            r.found_value = slot_val[pos];
                        end else begin
                            r.status = ST_DUPLICATE;
                        end
                        done = 1'b1;
                    end else begin
                        pos = (pos + 1) % SLOTS;
                        if (pos == home) done = 1'b1;  // full lap
                    end
                end
            end
            // only searches feed the saturating total
            if (kind == REQ_SEARCH) begin
                sum_wide   = longint'(search_sum) + compares;
                search_sum = (sum_wide > {SUM_W{1'b1}}) ? {SUM_W{1'b1}}
                                                         : sum_wide[SUM_W-1:0];
            end
            r.compares = compares[CNT_OUT_W-1:0];
            r.entries  = entry_count[CNT_OUT_W-1:0];
            r.total    = search_sum;
            status_tally[r.status]++;
            requests++;
            pending_results.push_back(r);
        endfunction

        function bit field_ok(string field, logic [31:0] want, logic [31:0] got);
            if (got === want) return 1'b1;
            if (errors < MAX_SHOWN)
                $display("result %0d: %s expected 0x%0h, got 0x%0h",
                         checked, field, want, got);
            return 1'b0;
        endfunction

        // Compare one result transaction with the oldest expectation
        function void check_result(logic [95:0] data);
            result_t want;
            bit      ok;
            if (pending_results.size() == 0) begin
                if (errors < MAX_SHOWN)
                    $display("result %0d: unexpected, data 0x%0h", checked, data);
                errors++;
                checked++;
                return;
            end
            want = pending_results.pop_front();
            ok = field_ok("status", want.status, data[2:0])
               & field_ok("probe_compares", want.compares, data[13:3])
               & field_ok("found_value", want.found_value, data[45:14])
               & field_ok("entries_now", want.entries, data[56:46])
               & field_ok("compare_total", want.total, data[88:57])
               & field_ok("padding", '0, data[95:89]);
            if (!ok) errors++;
            checked++;
        endfunction

        function int unsigned outstanding();
            return pending_results.size();
        endfunction

        function bit has_key(logic [KEY_IN_W-1:0] k);
            foreach (slot_used[s])
                if (slot_used[s] && slot_key[s] == k[KEY_BITS-1:0]) return 1'b1;
            return 1'b0;
        endfunction

        // A key with the given home slot that is not stored
        function logic [KEY_IN_W-1:0] absent_key(int unsigned home);
            logic [KEY_IN_W-1:0] k;
            do begin
                k = {6'($urandom_range(0, 63)), 10'(home)};
            end while (has_key(k));
            return k;
        endfunction

        function int unsigned free_slot_from(int unsigned start);
            for (int unsigned n = 0; n < SLOTS; n++)
                if (!slot_used[(start + n) % SLOTS]) return (start + n) % SLOTS;
            return start;
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Clock, reset and DUT
    // ------------------------------------------------------------------------
    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [47:0] s_tdata  = '0;   // [15:0] key_in, [47:16] value_in
    logic        s_tuser  = 1'b0; // [0] req_type
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [95:0] m_tdata;         // [2:0] status, [13:3] probe_compares,
                                  // [45:14] found_value, [56:46] entries_now,
                                  // [88:57] compare_total, [95:89] zero

    hash_table_scoreboard table_sb;
    bit          sender_steady = 1'b0;
    int unsigned quiet_cycles  = 0;

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    linear_probe_hash_table dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // ------------------------------------------------------------------------
    // Request driver: offer one transaction, wait for it, maybe idle a little
    // ------------------------------------------------------------------------
    task automatic send_request(input logic kind, input logic [KEY_IN_W-1:0] key,
                                input logic [VALUE_W-1:0] value);
        s_tvalid <= 1'b1;
        s_tdata  <= {value, key};
        s_tuser  <= kind;
        do @(posedge aclk); while (!s_tready);
        table_sb.note_request(kind, key, value);
        if (!sender_steady && $urandom_range(0, 99) < 7) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge aclk);
        end
    endtask

    // ------------------------------------------------------------------------
    // Result sink: check transactions, random stalls, one long hold-off
    // ------------------------------------------------------------------------
    initial begin : result_sink
        int unsigned hold_left;
        bit          held_once;
        hold_left = 0;
        held_once = 1'b0;
        forever begin
            @(posedge aclk);
            if (m_tvalid && m_tready) table_sb.check_result(m_tdata);
            if (!held_once && table_sb.checked == 600) begin
                held_once = 1'b1;
                hold_left = 250;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else if (table_sb.checked >= 900 && table_sb.checked < 1300) begin
                m_tready <= 1'b1;
            end else begin
                m_tready <= ($urandom_range(0, 99) >= 7);
            end
        end
    end

    // Watchdog: nothing moving on either stream for too long
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("watchdog: no transaction for %0d cycles", quiet_cycles);
            $display("linear_probe_hash_table: mismatch");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    initial begin : stimulus
        logic [KEY_IN_W-1:0] key_pool [POOL_SIZE];
        logic [KEY_IN_W-1:0] key;
        logic                kind;
        int unsigned         slot;
        table_sb = new();
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: empty-table miss, collisions at slot 0, wrap from 1023
        send_request(REQ_SEARCH, 16'h0000, 32'h0);
        send_request(REQ_INSERT, 16'h0000, 32'h0000_0000);
        send_request(REQ_INSERT, 16'hFFFF, 32'hFFFF_FFFF);
        send_request(REQ_INSERT, 16'h0400, 32'hA5A5_A5A5);
        send_request(REQ_INSERT, 16'hFC00, 32'h5A5A_5A5A);
        send_request(REQ_INSERT, 16'h03FF, 32'h0123_4567);
        // duplicate keeps the first value
        send_request(REQ_INSERT, 16'h0000, 32'h1234_5678);
        send_request(REQ_SEARCH, 16'h0000, 32'hFFFF_FFFF);
        send_request(REQ_SEARCH, 16'hFFFF, 32'h0);
        send_request(REQ_SEARCH, 16'h03FF, 32'h0);
        send_request(REQ_SEARCH, 16'h0800, 32'h0);
        send_request(REQ_SEARCH, 16'hFC00, 32'h0);
        send_request(REQ_INSERT, 16'h5555, 32'h5555_5555);
        send_request(REQ_INSERT, 16'hAAAA, 32'hAAAA_AAAA);
        send_request(REQ_SEARCH, 16'h5555, 32'h0);
        send_request(REQ_SEARCH, 16'hAAAA, 32'h0);
        send_request(REQ_SEARCH, 16'h07FF, 32'h0);
        send_request(REQ_INSERT, 16'h0001, 32'h0000_0001);
        send_request(REQ_SEARCH, 16'h0001, 32'h0);
        send_request(REQ_INSERT, 16'h0000, 32'h0);

        // key pool: a dense cluster for long probe chains, the rest spread out
        foreach (key_pool[i]) begin
            if (i < CLUSTER_KEYS)
                key_pool[i] = {6'($urandom_range(0, 63)), 10'($urandom_range(100, 163))};
            else
                key_pool[i] = {6'($urandom_range(0, 63)), 10'($urandom_range(0, SLOTS - 1))};
        end

        // random mix of inserts and searches at moderate load
        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            sender_steady = (i >= 700 && i < 1000);
            if (i == 1200) begin
                // let the block drain completely before going on
                s_tvalid <= 1'b0;
                do @(posedge aclk); while (table_sb.outstanding() != 0);
            end
            kind = ($urandom_range(0, 1) == 0) ? REQ_INSERT : REQ_SEARCH;
            if ($urandom_range(0, 9) < ((kind == REQ_INSERT) ? 9 : 7))
                key = key_pool[$urandom_range(0, POOL_SIZE - 1)];
            else
                key = 16'($urandom_range(0, 16'hFFFF));
            send_request(kind, key, $urandom());
        end
        sender_steady = 1'b0;

        // fill every remaining slot with a key whose home slot is free
        while (table_sb.entry_count < SLOTS) begin
            slot = table_sb.free_slot_from($urandom_range(0, SLOTS - 1));
            send_request(REQ_INSERT, {6'($urandom_range(0, 63)), 10'(slot)}, $urandom());
        end

        // full table: every miss walks a whole lap
        send_request(REQ_INSERT, table_sb.absent_key(SLOTS - 1), $urandom());
        send_request(REQ_INSERT, table_sb.absent_key(0), $urandom());
        send_request(REQ_SEARCH, table_sb.absent_key($urandom_range(0, SLOTS - 1)), $urandom());
        send_request(REQ_SEARCH, table_sb.absent_key(SLOTS - 1), $urandom());
        send_request(REQ_SEARCH, table_sb.slot_key[SLOTS - 1], $urandom());
        key = table_sb.slot_key[$urandom_range(0, SLOTS - 1)];
        send_request(REQ_SEARCH, key, $urandom());
        send_request(REQ_INSERT, key, $urandom());
        send_request(REQ_SEARCH, key, $urandom());

        // wait for the last results, then a margin for stray ones
        s_tvalid <= 1'b0;
        while (table_sb.outstanding() != 0) @(posedge aclk);
        repeat (40) @(posedge aclk);

        $display("%0d requests, %0d results checked, table filled to %0d of %0d slots",
                 table_sb.requests, table_sb.checked, table_sb.entry_count, SLOTS);
        $display("inserted %0d, duplicate %0d, full %0d, found %0d, not found %0d",
                 table_sb.status_tally[ST_INSERTED], table_sb.status_tally[ST_DUPLICATE],
                 table_sb.status_tally[ST_FULL], table_sb.status_tally[ST_FOUND],
                 table_sb.status_tally[ST_NOT_FOUND]);
        if (table_sb.errors == 0 && table_sb.outstanding() == 0)
            $display("linear_probe_hash_table: match");
        else
            $display("linear_probe_hash_table: mismatch");
        $finish;
    end

endmodule
